[design/twc_pkg.sv]
package twc_pkg;

  localparam int ALPHABET = 52;
  localparam int CODE_W   = 6;
  localparam int LETTER_W = 8;

  localparam logic [CODE_W-1:0] LAST_CODE  = CODE_W'(ALPHABET - 1);
  localparam logic [CODE_W-1:0] LOWER_BASE = CODE_W'(26);

  localparam logic [LETTER_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [LETTER_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [LETTER_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [LETTER_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // per-word failure record
  typedef enum logic [1:0] {
    FAIL_NONE = 2'd0,
    FAIL_FULL = 2'd1,
    FAIL_BAD  = 2'd2,
    FAIL_MISS = 2'd3
  } fail_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_COUNT = 4'b1000
  } state_t;

  // a missing lookup path reports ok with a zero count
  function automatic logic [1:0] status_of(input fail_t f);
    logic [1:0] s;
    s = ST_OK;
    if (f == FAIL_FULL) begin
      s = ST_FULL;
    end else if (f == FAIL_BAD) begin
      s = ST_BAD;
    end
    return s;
  endfunction

endpackage

[design/twc_letter_map.sv]
module twc_letter_map (
  input  logic [twc_pkg::LETTER_W-1:0] letter,
  output logic [twc_pkg::CODE_W-1:0]   code,
  output logic                         valid
);

  logic is_upper;
  logic is_lower;
  logic [twc_pkg::LETTER_W-1:0] upper_off;
  logic [twc_pkg::LETTER_W-1:0] lower_off;

  assign is_upper  = (letter >= twc_pkg::CHAR_UPPER_A) && (letter <= twc_pkg::CHAR_UPPER_Z);
  assign is_lower  = (letter >= twc_pkg::CHAR_LOWER_A) && (letter <= twc_pkg::CHAR_LOWER_Z);
  assign upper_off = letter - twc_pkg::CHAR_UPPER_A;
  assign lower_off = letter - twc_pkg::CHAR_LOWER_A;

  always_comb begin
    code  = '0;
    valid = 1'b0;
    if (is_upper) begin
      code  = upper_off[twc_pkg::CODE_W-1:0];
      valid = 1'b1;
    end else if (is_lower) begin
      code  = lower_off[twc_pkg::CODE_W-1:0] + twc_pkg::LOWER_BASE;
      valid = 1'b1;
    end
  end

endmodule

[design/trie_word_counter_top.sv]
// trie word counter: one letter per request, one result per insert or lookup word end
// a live letter: the request edge reads the child table, the next edge writes back
// done is registered in the count state after a clean word end, in the look state after a
// word end whose last letter fails in the table, and in idle after a word end on an already
// dead word or a bad byte; done is a 1-cycle pulse; no request is taken while busy is high
// reset sweeps all NODES rows of child slots, a clear only allocated rows, busy high; no stalls
module trie_word_counter_top #(
  parameter int NODES      = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  letter,
  input  logic        word_end,
  output logic        done,
  output logic [15:0] word_count,
  output logic [1:0]  status
);

  localparam int NODE_W      = $clog2(NODES);
  localparam int FREE_W      = NODE_W + 1;
  localparam int CHILD_DEPTH = NODES * twc_pkg::ALPHABET;
  localparam int ADDR_W      = $clog2(CHILD_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // child table entry: present bit on top of the child node index
  logic [NODE_W:0]         child_mem [CHILD_DEPTH];
  logic [COUNT_BITS-1:0]   count_mem [NODES];

  // memory ports
  logic                    child_re;
  logic                    child_we;
  logic [ADDR_W-1:0]       child_addr;
  logic [NODE_W:0]         child_wdata;
  logic [NODE_W:0]         child_rd;
  logic                    cnt_re;
  logic                    cnt_we;
  logic [NODE_W-1:0]       cnt_addr;
  logic [COUNT_BITS-1:0]   cnt_wdata;
  logic [COUNT_BITS-1:0]   cnt_rd;

  // control state
  twc_pkg::state_t         state;
  twc_pkg::fail_t          failed;
  logic [NODE_W-1:0]       current;
  logic [FREE_W-1:0]       next_free;
  logic [1:0]              mode_q;
  logic                    end_q;
  logic [ADDR_W-1:0]       slot_q;

  // clearing sweep
  logic [NODE_W-1:0]       clr_node;
  logic [twc_pkg::CODE_W-1:0] clr_code;
  logic [ADDR_W-1:0]       clr_addr;
  logic [NODE_W-1:0]       clr_last;

  // letter decode and slot address of the current node
  logic [twc_pkg::CODE_W-1:0] code;
  logic                    code_ok;
  logic [ADDR_W-1:0]       idle_addr;

  twc_letter_map u_letter_map (
    .letter (letter),
    .code   (code),
    .valid  (code_ok)
  );

  assign idle_addr = ADDR_W'(current) * ADDR_W'(twc_pkg::ALPHABET) + ADDR_W'(code);

  // outcome of the child lookup in the look state
  logic                    look_present;
  logic                    table_full;
  twc_pkg::fail_t          look_fail;
  logic                    look_alloc;
  logic [NODE_W-1:0]       look_node;

  assign look_present = child_rd[NODE_W];
  assign table_full   = (next_free >= FREE_W'(NODES));

  always_comb begin
    look_fail  = twc_pkg::FAIL_NONE;
    look_alloc = 1'b0;
    look_node  = next_free[NODE_W-1:0];
    if (look_present) begin
      look_node = child_rd[NODE_W-1:0];
    end else if (mode_q == twc_pkg::MODE_LOOKUP) begin
      look_fail = twc_pkg::FAIL_MISS;
    end else if (table_full) begin
      look_fail = twc_pkg::FAIL_FULL;
    end else begin
      look_alloc = 1'b1;
    end
  end

  // count update at the word end: saturating increment on insert only
  logic                    count_bump;
  logic [COUNT_BITS-1:0]   count_next;

  assign count_bump = (mode_q == twc_pkg::MODE_INSERT) && (cnt_rd != COUNT_MAX);
  assign count_next = count_bump ? (cnt_rd + COUNT_BITS'(1)) : cnt_rd;

  logic [15:0] count_out;

  generate
    if (COUNT_BITS >= 16) begin : g_count_wide
      assign count_out = count_next[15:0];
    end else begin : g_count_narrow
      assign count_out = {{(16 - COUNT_BITS){1'b0}}, count_next};
    end
  endgenerate

  // memory port control
  always_comb begin
    child_re    = 1'b0;
    child_we    = 1'b0;
    child_addr  = idle_addr;
    child_wdata = '0;
    cnt_re      = 1'b0;
    cnt_we      = 1'b0;
    cnt_addr    = current;
    cnt_wdata   = '0;
    unique case (state)
      twc_pkg::S_CLEAR: begin
        child_we   = 1'b1;
        child_addr = clr_addr;
        cnt_we     = (clr_code == '0);
        cnt_addr   = clr_node;
      end
      twc_pkg::S_IDLE: begin
        child_re = start && (mode == twc_pkg::MODE_INSERT || mode == twc_pkg::MODE_LOOKUP)
                   && (failed == twc_pkg::FAIL_NONE) && code_ok;
      end
      twc_pkg::S_LOOK: begin
        child_we    = look_alloc;
        child_addr  = slot_q;
        child_wdata = {1'b1, next_free[NODE_W-1:0]};
        // fetch the end node's count right away
        cnt_re      = end_q && (look_fail == twc_pkg::FAIL_NONE);
        cnt_addr    = look_node;
      end
      twc_pkg::S_COUNT: begin
        cnt_we    = count_bump;
        cnt_wdata = count_next;
      end
      default: begin
      end
    endcase
  end

  // child table: one port, registered read
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_addr] <= child_wdata;
    end
    if (child_re) begin
      child_rd <= child_mem[child_addr];
    end
  end

  // word count table: one port, registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_addr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd <= count_mem[cnt_addr];
    end
  end

  assign busy = (state != twc_pkg::S_IDLE);

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twc_pkg::S_CLEAR;
      clr_node  <= '0;
      clr_code  <= '0;
      clr_addr  <= '0;
      clr_last  <= NODE_W'(NODES - 1);
      next_free <= FREE_W'(1);
      current   <= '0;
      failed    <= twc_pkg::FAIL_NONE;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        twc_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_code == twc_pkg::LAST_CODE) begin
            clr_code <= '0;
            clr_node <= clr_node + NODE_W'(1);
            if (clr_node == clr_last) begin
              state <= twc_pkg::S_IDLE;
            end
          end else begin
            clr_code <= clr_code + twc_pkg::CODE_W'(1);
          end
        end

        twc_pkg::S_IDLE: begin
          if (start) begin
            mode_q <= mode;
            end_q  <= word_end;
            slot_q <= idle_addr;
            if (mode == twc_pkg::MODE_CLEAR) begin
              // only rows of allocated nodes can hold links or counts
              state     <= twc_pkg::S_CLEAR;
              clr_node  <= '0;
              clr_code  <= '0;
              clr_addr  <= '0;
              clr_last  <= NODE_W'(next_free - FREE_W'(1));
              next_free <= FREE_W'(1);
              current   <= '0;
              failed    <= twc_pkg::FAIL_NONE;
            end else if (mode == twc_pkg::MODE_INSERT || mode == twc_pkg::MODE_LOOKUP) begin
              if (failed == twc_pkg::FAIL_NONE && code_ok) begin
                state <= twc_pkg::S_LOOK;
              end else if (word_end) begin
                // word already dead or this byte is not a letter
                done       <= 1'b1;
                word_count <= '0;
                status     <= twc_pkg::status_of(
                                (failed == twc_pkg::FAIL_NONE) ? twc_pkg::FAIL_BAD : failed);
                current    <= '0;
                failed     <= twc_pkg::FAIL_NONE;
              end else if (failed == twc_pkg::FAIL_NONE) begin
                failed <= twc_pkg::FAIL_BAD;
              end
            end
          end
        end

        twc_pkg::S_LOOK: begin
          if (look_alloc) begin
            next_free <= next_free + FREE_W'(1);
          end
          if (look_fail == twc_pkg::FAIL_NONE) begin
            current <= look_node;
            state   <= end_q ? twc_pkg::S_COUNT : twc_pkg::S_IDLE;
          end else if (end_q) begin
            done       <= 1'b1;
            word_count <= '0;
            status     <= twc_pkg::status_of(look_fail);
            current    <= '0;
            failed     <= twc_pkg::FAIL_NONE;
            state      <= twc_pkg::S_IDLE;
          end else begin
            failed <= look_fail;
            state  <= twc_pkg::S_IDLE;
          end
        end

        twc_pkg::S_COUNT: begin
          done       <= 1'b1;
          word_count <= count_out;
          status     <= twc_pkg::ST_OK;
          current    <= '0;
          failed     <= twc_pkg::FAIL_NONE;
          state      <= twc_pkg::S_IDLE;
        end

        default: begin
          state <= twc_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/trie_word_counter_top_tb.sv]
module trie_word_counter_top_tb;

  localparam int NODES       = 4096;
  localparam int COUNT_BITS  = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  // mode 3 has no meaning; the block must ignore it
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int POOL_SLOTS  = 64;
  localparam int MAX_LEN     = 8;
  // the limit must outlast a full-table clear sweep, during which no request or result is accepted
  localparam int QUIET_LIMIT = 700000;
  localparam int MAX_REPORTS = 25;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] letter;
    logic       word_end;
  } letter_req_t;

  typedef struct packed {
    logic [15:0] count;
    logic [1:0]  status;
  } tally_t;

  // how a stored word is replayed
  typedef enum int {STYLE_INSERT, STYLE_LOOKUP, STYLE_MIXED} word_style_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic [1:0]  mode     = twc_pkg::MODE_INSERT;
  logic [7:0]  letter   = '0;
  logic        word_end = 1'b0;
  logic        busy;
  logic        done;
  logic [15:0] word_count;
  logic [1:0]  status;

  trie_word_counter_top #(
    .NODES(NODES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .letter(letter),
    .word_end(word_end),
    .done(done),
    .word_count(word_count),
    .status(status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // trie predictor: its own copy of links, counts, free pointer and walk state
  // ---------------------------------------------------------------------------
  int unsigned           child_of [int unsigned];   // key present = link present
  logic [COUNT_BITS-1:0] word_tally [NODES];
  int unsigned           free_node;
  int unsigned           walk_node;
  twc_pkg::fail_t        walk_fail;

  letter_req_t letters_to_send [$];   // requests waiting for the driver
  tally_t      tally_due [$];         // word results predicted, not yet seen

  int sender_gap_pct  = 0;
  int reqs_queued     = 0;
  int reqs_accepted   = 0;
  int letters_budget  = 0;            // counts only requests that do something
  int results_seen    = 0;
  int mismatches      = 0;
  int full_words      = 0;
  int bad_words       = 0;
  int miss_words      = 0;
  int saturated_words = 0;

  // replay pool of words known to the generator
  logic [7:0] pool_txt [POOL_SLOTS][MAX_LEN];
  int         pool_len [POOL_SLOTS];
  int         pool_n = 0;

  function automatic void wipe_trie();
    child_of.delete();
    foreach (word_tally[i]) word_tally[i] = '0;
    free_node = 1;
    walk_node = 0;
    walk_fail = twc_pkg::FAIL_NONE;
  endfunction

  // A-Z -> 0..25, a-z -> 26..51, anything else -> -1
  function automatic int letter_index(input logic [7:0] b);
    if (b >= twc_pkg::CHAR_UPPER_A && b <= twc_pkg::CHAR_UPPER_Z)
      return int'(b - twc_pkg::CHAR_UPPER_A);
    if (b >= twc_pkg::CHAR_LOWER_A && b <= twc_pkg::CHAR_LOWER_Z)
      return int'(b - twc_pkg::CHAR_LOWER_A) + int'(twc_pkg::LOWER_BASE);
    return -1;
  endfunction

  function automatic logic [7:0] ascii_of(input int code);
    if (code < 26) return twc_pkg::CHAR_UPPER_A + 8'(code);
    return twc_pkg::CHAR_LOWER_A + 8'(code - 26);
  endfunction

  // one accepted request: walk or allocate, and at a word end predict the result
  function automatic void advance_trie(input letter_req_t r);
    int          code;
    int unsigned slot;
    tally_t      t;
    if (r.mode == twc_pkg::MODE_CLEAR) begin
      wipe_trie();
      return;
    end
    if (r.mode == MODE_IGNORED) return;
    // first failure in a word wins; later letters change nothing
    if (walk_fail == twc_pkg::FAIL_NONE) begin
      code = letter_index(r.letter);
      if (code < 0) begin
        walk_fail = twc_pkg::FAIL_BAD;
      end else begin
        slot = walk_node * twc_pkg::ALPHABET + code;
        if (child_of.exists(slot)) begin
          walk_node = child_of[slot];
        end else if (r.mode == twc_pkg::MODE_LOOKUP) begin
          walk_fail = twc_pkg::FAIL_MISS;
        end else if (free_node >= NODES) begin
          walk_fail = twc_pkg::FAIL_FULL;
        end else begin
          child_of[slot] = free_node;
          walk_node = free_node;
          free_node++;
        end
      end
    end
    if (!r.word_end) return;
    t.count  = '0;
    t.status = twc_pkg::ST_OK;
    case (walk_fail)
      twc_pkg::FAIL_NONE: begin
        if (r.mode == twc_pkg::MODE_INSERT) begin
          if (word_tally[walk_node] != COUNT_MAX) word_tally[walk_node]++;
          else saturated_words++;
        end
        t.count = 16'(word_tally[walk_node]);
      end
      twc_pkg::FAIL_FULL: begin
        t.status = twc_pkg::ST_FULL;
        full_words++;
      end
      twc_pkg::FAIL_BAD: begin
        t.status = twc_pkg::ST_BAD;
        bad_words++;
      end
      default: miss_words++;   // missing lookup path reports zero with ok status
    endcase
    tally_due.insert(tally_due.size(), t);
    walk_node = 0;
    walk_fail = twc_pkg::FAIL_NONE;
  endfunction

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------
  function automatic void push_req(input logic [1:0] m, input logic [7:0] b,
                                   input logic e);
    letter_req_t r;
    r.mode     = m;
    r.letter   = b;
    r.word_end = e;
    letters_to_send.insert(letters_to_send.size(), r);
    reqs_queued++;
    if (m != MODE_IGNORED) letters_budget++;
  endfunction

  function automatic logic [7:0] random_bad_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (letter_index(b) >= 0) b = 8'($urandom_range(255));
    return b;
  endfunction

  // narrow words draw from A-D or w-z so that prefixes are shared often
  function automatic int fresh_word(input bit narrow);
    int slot;
    int low;
    low = $urandom_range(1) ? 0 : 48;
    if (pool_n < POOL_SLOTS) begin
      slot = pool_n;
      pool_n++;
    end else begin
      slot = $urandom_range(POOL_SLOTS - 1);
    end
    pool_len[slot] = $urandom_range(MAX_LEN, 1);
    for (int i = 0; i < pool_len[slot]; i++)
      pool_txt[slot][i] = ascii_of(narrow ? low + $urandom_range(3) : $urandom_range(51));
    return slot;
  endfunction

  // send the first stop letters of a pooled word, optionally spoiling one letter
  function automatic void queue_word(input int slot, input word_style_t style,
                                     input int stop, input int bad_at);
    logic [1:0] m;
    logic [7:0] b;
    for (int i = 0; i < stop; i++) begin
      case (style)
        STYLE_INSERT: m = twc_pkg::MODE_INSERT;
        STYLE_LOOKUP: m = twc_pkg::MODE_LOOKUP;
        default:      m = $urandom_range(1) ? twc_pkg::MODE_INSERT : twc_pkg::MODE_LOOKUP;
      endcase
      b = (i == bad_at) ? random_bad_byte() : pool_txt[slot][i];
      push_req(m, b, i == stop - 1);
    end
  endfunction

  // mostly well-formed words over a replay pool, plus noise and the odd clear
  function automatic void random_phase(input int budget);
    int         goal;
    int         slot;
    int         pick;
    logic [1:0] m;
    goal = letters_budget + budget;
    while (letters_budget < goal) begin
      pick = $urandom_range(99);
      if (pick < 30 || pool_n == 0) begin
        slot = fresh_word($urandom_range(99) < 70);
        queue_word(slot, (pick < 6) ? STYLE_LOOKUP : STYLE_INSERT, pool_len[slot], -1);
      end else begin
        slot = $urandom_range(pool_n - 1);
        if (pick < 52) begin
          queue_word(slot, STYLE_LOOKUP, pool_len[slot], -1);
        end else if (pick < 64) begin
          queue_word(slot, STYLE_INSERT, pool_len[slot], -1);
        end else if (pick < 72) begin
          queue_word(slot, STYLE_MIXED, pool_len[slot], -1);
        end else if (pick < 78) begin
          queue_word(slot, STYLE_LOOKUP, $urandom_range(pool_len[slot], 1), -1);
        end else if (pick < 82) begin
          queue_word(slot, STYLE_INSERT, $urandom_range(pool_len[slot], 1), -1);
        end else if (pick < 88) begin
          queue_word(slot, STYLE_MIXED, pool_len[slot],
                     $urandom_range(pool_len[slot] - 1));
        end else if (pick < 97) begin
          // raw noise: any byte, any end mark, insert, lookup or the unused mode
          repeat ($urandom_range(3, 1)) begin
            m = 2'($urandom_range(2));
            if (m == twc_pkg::MODE_CLEAR) m = MODE_IGNORED;
            push_req(m, 8'($urandom_range(255)), 1'($urandom_range(1)));
          end
        end else begin
          push_req(twc_pkg::MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
          pool_n = 0;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: prediction happens at the accepting edge, then the next request
  // is presented (or start drops for a random gap)
  // ---------------------------------------------------------------------------
  letter_req_t on_port;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_trie(on_port);
        reqs_accepted++;
      end
      if (!start || !busy) begin
        if (letters_to_send.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          on_port = letters_to_send.pop_front();
          start    <= 1'b1;
          mode     <= on_port.mode;
          letter   <= on_port.letter;
          word_end <= on_port.word_end;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each done strobe is checked against the oldest predicted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tally_t want;
    if (!rst && done === 1'b1) begin
      if (tally_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: expected no result, actual count %0d status %0d", $time,
                   word_count, status);
      end else begin
        want = tally_due.pop_front();
        results_seen++;
        if (word_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: word_count expected %0d actual %0d", $time,
                     want.count, word_count);
        end
        if (status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, status);
        end
      end
    end
  end

  // watchdog on cycles with neither a request nor a result accepted
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // wait until every queued request is taken and every result has come back,
  // then give a late or stray strobe a chance to show up
  task automatic drain();
    while (reqs_accepted != reqs_queued || tally_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int slot;
    wipe_trie();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: letter extremes, both modes, misses, bad bytes, mode 3, clear
    sender_gap_pct = 0;
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_UPPER_A, 1'b1);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_LOWER_Z, 1'b1);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_UPPER_A, 1'b1);
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_UPPER_A, 1'b1);
    // lookup down a path that does not exist yet
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_UPPER_A, 1'b0);
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_LOWER_Z, 1'b1);
    // mixed modes: walk by lookup, end by insert
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_UPPER_A, 1'b0);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_LOWER_Z, 1'b1);
    // a missed lookup is not undone by a later insert letter
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_UPPER_Z, 1'b0);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_LOWER_A, 1'b1);
    // bytes just outside both letter ranges, and the byte extremes
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_UPPER_A - 8'd1, 1'b1);
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_UPPER_Z + 8'd1, 1'b1);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_LOWER_A - 8'd1, 1'b0);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_LOWER_A, 1'b1);
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_LOWER_Z + 8'd1, 1'b1);
    push_req(twc_pkg::MODE_INSERT, 8'h00, 1'b1);
    push_req(twc_pkg::MODE_INSERT, 8'hFF, 1'b1);
    // the unused mode in the middle of a word leaves the walk alone
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_UPPER_A, 1'b0);
    push_req(MODE_IGNORED, 8'hFF, 1'b1);
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_LOWER_Z, 1'b1);
    // clear in the middle of a word drops the walk and the contents
    push_req(twc_pkg::MODE_INSERT, twc_pkg::CHAR_UPPER_Z, 1'b0);
    push_req(twc_pkg::MODE_CLEAR, twc_pkg::CHAR_UPPER_A, 1'b1);
    push_req(twc_pkg::MODE_LOOKUP, twc_pkg::CHAR_UPPER_A, 1'b1);
    drain();

    // random phases with different sender gap rates
    for (int p = 0; p < 4; p++) begin
      sender_gap_pct = (p == 1) ? 58 : (p == 2) ? 30 : 0;
      random_phase(220);
      drain();
    end

    // store a word, clear, and make sure the store really is empty
    sender_gap_pct = 30;
    slot = fresh_word(1'b0);
    queue_word(slot, STYLE_INSERT, pool_len[slot], -1);
    push_req(twc_pkg::MODE_CLEAR, 8'($urandom_range(255)), 1'b0);
    queue_word(slot, STYLE_LOOKUP, pool_len[slot], -1);
    pool_n = 0;
    random_phase(60);
    drain();

    repeat (16) @(posedge clk);
    $display("covered %0d requests and %0d word results", reqs_accepted, results_seen);
    $display("table full %0d, bad letter %0d, missed lookup %0d, saturated %0d",
             full_words, bad_words, miss_words, saturated_words);
    if (tally_due.size() > 0)
      $display("%0d predicted results never arrived", tally_due.size());
    if (mismatches == 0 && tally_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
